// File: hdl/pressure_temp_sensor_poll_sequencer_assert.svh
// Assertion macros for the sensor poll sequencer.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PRESSURE_TEMP_SENSOR_POLL_SEQUENCER_ASSERT_SVH
`define PRESSURE_TEMP_SENSOR_POLL_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pts_pkg.sv
// Types and constants for the pressure/temperature sensor poll sequencer.
// No dependencies; imported by all modules of the block.
package pts_pkg;

	// Sensor commands
	localparam logic [7:0] CMD_CONVERT_D1 = 8'h4A;
	localparam logic [7:0] CMD_CONVERT_D2 = 8'h5A;
	localparam logic [7:0] CMD_ADC_READ   = 8'h00;
	localparam logic [1:0] ADC_READ_LEN   = 2'd3;
	localparam logic [1:0] CMD_ONLY_LEN   = 2'd0;

	// Register indexes on the config port
	localparam logic [1:0] REG_D1_WAIT   = 2'd0;
	localparam logic [1:0] REG_D2_WAIT   = 2'd1;
	localparam logic [1:0] REG_IDLE_WAIT = 2'd2;

	// Reported phase codes
	localparam logic [2:0] PHASE_CODE_INIT     = 3'd0;
	localparam logic [2:0] PHASE_CODE_IDLE     = 3'd1;
	localparam logic [2:0] PHASE_CODE_WAIT_D1  = 3'd2;
	localparam logic [2:0] PHASE_CODE_START_D2 = 3'd3;
	localparam logic [2:0] PHASE_CODE_WAIT_D2  = 3'd4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_DONE  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		TAG_D1_CONV = 2'd0,
		TAG_D1_READ = 2'd1,
		TAG_D2_CONV = 2'd2,
		TAG_D2_READ = 2'd3
	} tag_t;

	typedef enum logic [4:0] {
		PH_INIT     = 5'b00001,
		PH_IDLE     = 5'b00010,
		PH_WAIT_D1  = 5'b00100,
		PH_START_D2 = 5'b01000,
		PH_WAIT_D2  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [15:0] d1_wait;
		logic [15:0] d2_wait;
		logic [15:0] idle_wait;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic       bus_busy;
		tag_t       done_tag;
		logic [7:0] byte_high;
		logic [7:0] byte_low;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic        armed;
		logic [15:0] count;
		logic [15:0] pressure;
		logic [15:0] temperature;
		logic [15:0] conversions;
	} seq_state_t;

	typedef struct packed {
		logic        request_valid;
		logic [7:0]  command_byte;
		logic [1:0]  read_length;
		tag_t        request_tag;
		logic [15:0] pressure_raw;
		logic [15:0] temperature_raw;
		logic [15:0] cycle_count;
		logic [2:0]  phase;
	} result_t;

endpackage

// File: hdl/pressure_temp_sensor_poll_sequencer.sv
// Top level of the pressure/temperature sensor poll sequencer.
// Depends on pts_pkg, pts_cfg_regs, pts_step and the assertion macro header.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | tuser: operation; tdata: bus_busy, done_tag,
//            |     |                    |   byte_high, byte_low
//  m_*       | out | m_tvalid/m_tready  | tdata: request, readings, cycle_count, phase
//  cfg_*     | in  | cfg_we             | cfg_index selects a wait register, cfg_data
//
// One item per clock while m_tready is high; an item passes the input register, then the
// step logic and sequencer state update into the result register.
// Reset: phase init, timer armed at zero, readings and cycle count cleared, wait
// registers zero.
// Stalls: while m_tready is low the result register holds; the input register
// takes one more transfer and then s_tready drops until the result is taken.
// The sequencer state advances exactly when an item moves into the result register.
module pressure_temp_sensor_poll_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] operation
	input  logic [23:0] s_tdata,   // [0] bus_busy, [2:1] done_tag, [10:3] byte_high,
	                               // [18:11] byte_low, [23:19] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [0] request_valid, [8:1] command_byte,
	                               // [10:9] read_length, [12:11] request_tag,
	                               // [28:13] pressure_raw, [44:29] temperature_raw,
	                               // [60:45] cycle_count, [63:61] phase
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pts_pkg::*;

	`include "pressure_temp_sensor_poll_sequencer_assert.svh"

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	seq_state_t state_q;
	seq_state_t state_next;
	result_t    res_next;
	logic       advance;

	pts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pts_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_next),
		.res  (res_next)
	);

	// result register is free or being drained this cycle
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op        <= s_tuser;
			item_s1.bus_busy  <= s_tdata[0];
			item_s1.done_tag  <= tag_t'(s_tdata[2:1]);
			item_s1.byte_high <= s_tdata[10:3];
			item_s1.byte_low  <= s_tdata[18:11];
		end
	end

	// sequencer state: one update per item entering the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_INIT;
			state_q.armed       <= 1'b1;
			state_q.count       <= '0;
			state_q.pressure    <= '0;
			state_q.temperature <= '0;
			state_q.conversions <= '0;
		end else if (advance && valid_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.phase, res_s2.cycle_count, res_s2.temperature_raw,
	                   res_s2.pressure_raw, res_s2.request_tag, res_s2.read_length,
	                   res_s2.command_byte, res_s2.request_valid};

	// an issued request always leaves the timer disarmed
	`PTS_ASSERT_NEXT(a_req_disarms, clk, arst_n, advance && valid_s1 && res_next.request_valid, !state_q.armed, "request issued but timer still armed")

	// a stalled input item is neither lost nor altered
	`PTS_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1), "input register changed while stalled")

	// cycle count moves only on a D1 conversion done event
	`PTS_ASSERT_NEXT(a_count_only_d1, clk, arst_n, !(advance && valid_s1 && item_s1.op == OP_DONE && item_s1.done_tag == TAG_D1_CONV), $stable(state_q.conversions), "cycle count changed without D1 conversion done")

	// state never moves without an item entering the result register
	`PTS_ASSERT_NEXT(a_state_hold, clk, arst_n, !(advance && valid_s1), $stable(state_q), "sequencer state changed without an item")

endmodule

// File: hdl/pts_cfg_regs.sv
// Wait-time register file for the sensor poll sequencer.
// Depends on pts_pkg (cfg_t, register indexes).
module pts_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output pts_pkg::cfg_t   cfg
);
	import pts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_D1_WAIT:   cfg_q.d1_wait   <= cfg_data;
				REG_D2_WAIT:   cfg_q.d2_wait   <= cfg_data;
				REG_IDLE_WAIT: cfg_q.idle_wait <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/pts_step.sv
// Per-item update of the sequencer: next state and the result for one item.
// Depends on pts_pkg (item, state, config and result types).
module pts_step (
	input  pts_pkg::item_t      item,
	input  pts_pkg::seq_state_t cur,
	input  pts_pkg::cfg_t       cfg,
	output pts_pkg::seq_state_t nxt,
	output pts_pkg::result_t    res
);
	import pts_pkg::*;

	always_comb begin
		nxt = cur;
		res = '0;

		unique case (op_t'(item.op))
			OP_TICK: begin
				if (cur.armed) begin
					if (cur.count != 16'd0) begin
						nxt.count = cur.count - 16'd1;
					end else begin
						nxt.armed = 1'b0;
						if (cur.phase != PH_INIT) begin
							if (item.bus_busy) begin
								// retry after the idle wait
								nxt.armed = 1'b1;
								nxt.count = cfg.idle_wait;
							end else begin
								res.request_valid = 1'b1;
								unique case (cur.phase)
									PH_IDLE: begin
										res.command_byte = CMD_CONVERT_D1;
										res.read_length  = CMD_ONLY_LEN;
										res.request_tag  = TAG_D1_CONV;
									end
									PH_WAIT_D1: begin
										res.command_byte = CMD_ADC_READ;
										res.read_length  = ADC_READ_LEN;
										res.request_tag  = TAG_D1_READ;
									end
									PH_START_D2: begin
										res.command_byte = CMD_CONVERT_D2;
										res.read_length  = CMD_ONLY_LEN;
										res.request_tag  = TAG_D2_CONV;
									end
									default: begin
										res.command_byte = CMD_ADC_READ;
										res.read_length  = ADC_READ_LEN;
										res.request_tag  = TAG_D2_READ;
									end
								endcase
							end
						end
					end
				end
			end
			OP_START: begin
				nxt.phase = PH_IDLE;
				nxt.armed = 1'b1;
				nxt.count = 16'd0;
			end
			OP_DONE: begin
				nxt.armed = 1'b1;
				unique case (item.done_tag)
					TAG_D1_CONV: begin
						nxt.conversions = cur.conversions + 16'd1;
						nxt.phase       = PH_WAIT_D1;
						nxt.count       = cfg.d1_wait;
					end
					TAG_D1_READ: begin
						nxt.pressure = {item.byte_high, item.byte_low};
						nxt.phase    = PH_START_D2;
						nxt.count    = 16'd0;
					end
					TAG_D2_CONV: begin
						nxt.phase = PH_WAIT_D2;
						nxt.count = cfg.d2_wait;
					end
					TAG_D2_READ: begin
						nxt.temperature = {item.byte_high, item.byte_low};
						nxt.phase       = PH_IDLE;
						nxt.count       = cfg.idle_wait;
					end
				endcase
			end
			default: ;  // unused operation code
		endcase

		res.pressure_raw    = nxt.pressure;
		res.temperature_raw = nxt.temperature;
		res.cycle_count     = nxt.conversions;
		unique case (nxt.phase)
			PH_IDLE:     res.phase = PHASE_CODE_IDLE;
			PH_WAIT_D1:  res.phase = PHASE_CODE_WAIT_D1;
			PH_START_D2: res.phase = PHASE_CODE_START_D2;
			PH_WAIT_D2:  res.phase = PHASE_CODE_WAIT_D2;
			default:     res.phase = PHASE_CODE_INIT;
		endcase
	end

endmodule
